// ----- sv/dsr_pkg.sv -----
package dsr_pkg;

    localparam int ID_W   = 6;
    localparam int SLOT_W = 3;
    localparam int SUSP_W = 4;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET_RELATION  = 2'd0,
        ACT_FIND          = 2'd1,
        ACT_WRITE_SUSPEND = 2'd2,
        ACT_NOP           = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK            = 3'd0,
        ST_NOT_DEBUGGER  = 3'd1,
        ST_TABLE_FULL    = 3'd3,
        ST_ILLEGAL       = 3'd4,
        ST_DBG_NOT_FOUND = 3'd5,
        ST_LOOKUP_FAILED = 3'd6
    } status_t;

    // How a decoded request continues after the decode cycle.
    typedef enum logic [1:0] {
        ROUTE_FINAL  = 2'd0,
        ROUTE_UNREG  = 2'd1,
        ROUTE_TARGET = 2'd2
    } route_t;

    localparam logic KIND_FINAL    = 1'b0;
    localparam logic KIND_CONTINUE = 1'b1;

    typedef struct packed {
        logic load;
        logic emit_decode;
        logic unreg_begin;
        logic target_eval;
        logic sweep;
        logic final_emit;
    } cmd_t;

    typedef struct packed {
        route_t route;
        logic   tgt_cont;
        logic   sweep_last;
    } sts_t;

endpackage

// ----- sv/dsr_controller.sv -----
module dsr_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dsr_pkg::sts_t sts,
    output dsr_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_TARGET = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINAL  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.route == dsr_pkg::ROUTE_UNREG)
                begin
                    cmd.unreg_begin = 1'b1;
                    state_next      = S_SWEEP;
                end
                else if (sts.route == dsr_pkg::ROUTE_TARGET)
                begin
                    state_next = S_TARGET;
                end
                else
                begin
                    cmd.emit_decode = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_TARGET:
            begin
                cmd.target_eval = 1'b1;
                state_next      = sts.tgt_cont ? S_FINAL : S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.final_emit = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- sv/dsr_datapath.sv -----
module dsr_datapath #(
    parameter int SLOT_COUNT    = 6,
    parameter int PROCESS_COUNT = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dsr_pkg::cmd_t               cmd,
    output dsr_pkg::sts_t               sts,
    input  logic [dsr_pkg::ACT_W-1:0]   action,
    input  logic                        debugger_present,
    input  logic                        debugger_found,
    input  logic [dsr_pkg::ID_W-1:0]    debugger_id,
    input  logic                        target_present,
    input  logic                        target_found,
    input  logic [dsr_pkg::ID_W-1:0]    target_id,
    input  logic [dsr_pkg::SUSP_W-1:0]  suspend_bits,
    output logic                        strobe,
    output logic                        kind,
    output logic [dsr_pkg::STAT_W-1:0]  status,
    output logic [dsr_pkg::SLOT_W-1:0]  slot_index,
    output logic [dsr_pkg::ID_W-1:0]    continue_id,
    output logic                        last
);

    localparam int PW    = $clog2(PROCESS_COUNT + 1);
    localparam int DEPTH = 2 ** PW;

    // Captured request.
    dsr_pkg::action_t              act_reg;
    logic                          dp_reg;
    logic                          df_reg;
    logic [dsr_pkg::ID_W-1:0]      did_reg;
    logic                          tp_reg;
    logic                          tf_reg;
    logic [dsr_pkg::ID_W-1:0]      tid_reg;
    logic [dsr_pkg::SUSP_W-1:0]    sb_reg;

    // Slot table.
    logic [dsr_pkg::ID_W-1:0]      slot_owner_reg [1:SLOT_COUNT];

    // Per-process memories with valid bits standing in for the reset value.
    logic [dsr_pkg::SLOT_W-1:0]    pds_mem  [DEPTH];
    logic [dsr_pkg::SUSP_W-1:0]    susp_mem [DEPTH];
    logic [DEPTH-1:0]              pds_valid_reg;
    logic [DEPTH-1:0]              susp_valid_reg;
    logic [dsr_pkg::SLOT_W-1:0]    pds_rd_reg;
    logic [dsr_pkg::SUSP_W-1:0]    susp_rd_reg;
    logic                          pds_rv_reg;
    logic                          susp_rv_reg;
    logic [dsr_pkg::SLOT_W-1:0]    pds_eff;
    logic [dsr_pkg::SUSP_W-1:0]    susp_eff;
    logic [PW-1:0]                 rd_idx;
    logic [PW-1:0]                 tid_idx;

    logic                          pds_we;
    logic [PW-1:0]                 pds_wa;
    logic [dsr_pkg::SLOT_W-1:0]    pds_wd;
    logic                          susp_we;

    // Sweep over all processes.
    logic [PW-1:0]                 sweep_cnt_reg;
    logic                          eval_vld_reg;
    logic [PW-1:0]                 eval_j_reg;
    logic                          sweep_hit;

    // Result latched for a final beat that follows continue beats.
    dsr_pkg::status_t              fin_status_reg;
    logic [dsr_pkg::SLOT_W-1:0]    fin_slot_reg;

    // Decode.
    logic                          did_ok;
    logic                          tid_ok;
    logic [dsr_pkg::SLOT_W-1:0]    found_slot;
    logic [dsr_pkg::SLOT_W-1:0]    open_slot;
    logic [dsr_pkg::SLOT_W-1:0]    attach_slot;
    dsr_pkg::route_t               route;
    dsr_pkg::status_t              dec_status;
    logic [dsr_pkg::SLOT_W-1:0]    dec_slot;
    logic                          is_detach;
    logic                          tgt_cont;

    // Result beat.
    logic                          emit;
    logic                          e_kind;
    dsr_pkg::status_t              e_status;
    logic [dsr_pkg::SLOT_W-1:0]    e_slot;
    logic [dsr_pkg::ID_W-1:0]      e_cid;
    logic                          strobe_reg;
    logic                          kind_reg;
    dsr_pkg::status_t              status_reg;
    logic [dsr_pkg::SLOT_W-1:0]    slot_reg;
    logic [dsr_pkg::ID_W-1:0]      cid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= dsr_pkg::action_t'(action);
            dp_reg  <= debugger_present;
            df_reg  <= debugger_found;
            did_reg <= debugger_id;
            tp_reg  <= target_present;
            tf_reg  <= target_found;
            tid_reg <= target_id;
            sb_reg  <= suspend_bits;
        end
    end

    assign did_ok  = (did_reg != '0) && (did_reg <= dsr_pkg::ID_W'(PROCESS_COUNT));
    assign tid_ok  = (tid_reg != '0) && (tid_reg <= dsr_pkg::ID_W'(PROCESS_COUNT));
    assign tid_idx = tid_reg[PW-1:0];

    // Lowest slot owned by the debugger, and lowest free slot.
    always_comb
    begin
        found_slot = '0;
        open_slot  = '0;
        for (int i = SLOT_COUNT; i >= 1; i--)
        begin
            if (slot_owner_reg[i] == did_reg)
            begin
                found_slot = dsr_pkg::SLOT_W'(i);
            end
            if (slot_owner_reg[i] == '0)
            begin
                open_slot = dsr_pkg::SLOT_W'(i);
            end
        end
    end

    assign attach_slot = (found_slot != '0) ? found_slot : open_slot;

    always_comb
    begin
        route      = dsr_pkg::ROUTE_FINAL;
        dec_status = dsr_pkg::ST_OK;
        dec_slot   = '0;
        unique case (act_reg)
            dsr_pkg::ACT_FIND:
            begin
                if (did_ok && found_slot != '0)
                begin
                    dec_slot = found_slot;
                end
                else
                begin
                    dec_status = dsr_pkg::ST_NOT_DEBUGGER;
                end
            end
            dsr_pkg::ACT_WRITE_SUSPEND, dsr_pkg::ACT_NOP:
            begin
                dec_slot = '0;
            end
            dsr_pkg::ACT_SET_RELATION:
            begin
                if (!tp_reg)
                begin
                    if (dp_reg)
                    begin
                        if (!df_reg || !did_ok)
                        begin
                            dec_status = dsr_pkg::ST_LOOKUP_FAILED;
                        end
                        else if (found_slot == '0)
                        begin
                            dec_status = dsr_pkg::ST_NOT_DEBUGGER;
                        end
                        else
                        begin
                            route    = dsr_pkg::ROUTE_UNREG;
                            dec_slot = found_slot;
                        end
                    end
                end
                else if (!tf_reg || !tid_ok)
                begin
                    dec_status = dsr_pkg::ST_LOOKUP_FAILED;
                end
                else if (!dp_reg)
                begin
                    route = dsr_pkg::ROUTE_TARGET;
                end
                else if (!df_reg || !did_ok)
                begin
                    dec_status = dsr_pkg::ST_DBG_NOT_FOUND;
                end
                else if (did_reg == tid_reg)
                begin
                    if (found_slot == '0)
                    begin
                        dec_status = dsr_pkg::ST_NOT_DEBUGGER;
                    end
                    else
                    begin
                        route    = dsr_pkg::ROUTE_UNREG;
                        dec_slot = found_slot;
                    end
                end
                else if (attach_slot == '0)
                begin
                    dec_status = dsr_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    route = dsr_pkg::ROUTE_TARGET;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= SLOT_COUNT; i++)
            begin
                slot_owner_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 1; i <= SLOT_COUNT; i++)
            begin
                if (cmd.unreg_begin && found_slot == dsr_pkg::SLOT_W'(i))
                begin
                    slot_owner_reg[i] <= '0;
                end
                else if (cmd.target_eval && dp_reg && found_slot == '0 &&
                         open_slot == dsr_pkg::SLOT_W'(i))
                begin
                    slot_owner_reg[i] <= did_reg;
                end
            end
        end
    end

    // Memory read port: the sweep address while sweeping, else the target.
    assign rd_idx = cmd.sweep ? sweep_cnt_reg : tid_idx;

    always_ff @(posedge clk)
    begin
        pds_rd_reg  <= pds_mem[rd_idx];
        susp_rd_reg <= susp_mem[rd_idx];
        if (pds_we)
        begin
            pds_mem[pds_wa] <= pds_wd;
        end
        if (susp_we)
        begin
            susp_mem[tid_idx] <= sb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pds_valid_reg  <= '0;
            susp_valid_reg <= '0;
            pds_rv_reg     <= 1'b0;
            susp_rv_reg    <= 1'b0;
        end
        else
        begin
            pds_rv_reg  <= pds_valid_reg[rd_idx];
            susp_rv_reg <= susp_valid_reg[rd_idx];
            if (pds_we)
            begin
                pds_valid_reg[pds_wa] <= 1'b1;
            end
            if (susp_we)
            begin
                susp_valid_reg[tid_idx] <= 1'b1;
            end
        end
    end

    assign pds_eff  = pds_rv_reg  ? pds_rd_reg  : '0;
    assign susp_eff = susp_rv_reg ? susp_rd_reg : '0;

    assign is_detach = !dp_reg;
    assign tgt_cont  = is_detach && (pds_eff != '0) && (susp_eff != '0);
    assign sweep_hit = eval_vld_reg && (pds_eff == fin_slot_reg);

    always_comb
    begin
        pds_we = 1'b0;
        pds_wa = tid_idx;
        pds_wd = '0;
        if (sweep_hit)
        begin
            pds_we = 1'b1;
            pds_wa = eval_j_reg;
        end
        else if (cmd.target_eval)
        begin
            if (is_detach)
            begin
                pds_we = (pds_eff != '0);
            end
            else
            begin
                pds_we = 1'b1;
                pds_wd = attach_slot;
            end
        end
    end

    assign susp_we = cmd.emit_decode && (act_reg == dsr_pkg::ACT_WRITE_SUSPEND) && tid_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_vld_reg <= 1'b0;
        end
        else
        begin
            eval_vld_reg <= cmd.sweep;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_j_reg <= sweep_cnt_reg;
        if (cmd.unreg_begin)
        begin
            sweep_cnt_reg <= PW'(1);
        end
        else if (cmd.sweep)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + PW'(1);
        end
        if (cmd.unreg_begin)
        begin
            fin_status_reg <= dsr_pkg::ST_OK;
            fin_slot_reg   <= found_slot;
        end
        else if (cmd.target_eval)
        begin
            fin_status_reg <= dsr_pkg::ST_OK;
            fin_slot_reg   <= '0;
        end
    end

    assign sts.route      = route;
    assign sts.tgt_cont   = tgt_cont;
    assign sts.sweep_last = (sweep_cnt_reg == PW'(PROCESS_COUNT));

    always_comb
    begin
        emit     = 1'b0;
        e_kind   = dsr_pkg::KIND_FINAL;
        e_status = dsr_pkg::ST_OK;
        e_slot   = '0;
        e_cid    = '0;
        priority if (cmd.emit_decode)
        begin
            emit     = 1'b1;
            e_status = dec_status;
            e_slot   = dec_slot;
        end
        else if (cmd.final_emit)
        begin
            emit     = 1'b1;
            e_status = fin_status_reg;
            e_slot   = fin_slot_reg;
        end
        else if (cmd.target_eval)
        begin
            emit = 1'b1;
            if (is_detach)
            begin
                if (tgt_cont)
                begin
                    e_kind = dsr_pkg::KIND_CONTINUE;
                    e_cid  = tid_reg;
                end
            end
            else
            begin
                e_status = (pds_eff != '0) ? dsr_pkg::ST_ILLEGAL : dsr_pkg::ST_OK;
                e_slot   = attach_slot;
            end
        end
        else if (sweep_hit && susp_eff != '0)
        begin
            emit   = 1'b1;
            e_kind = dsr_pkg::KIND_CONTINUE;
            e_cid  = dsr_pkg::ID_W'(eval_j_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg   <= e_kind;
            status_reg <= e_status;
            slot_reg   <= e_slot;
            cid_reg    <= e_cid;
        end
    end

    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign continue_id = cid_reg;
    assign last        = (kind_reg == dsr_pkg::KIND_FINAL);

endmodule

// ----- sv/debugger_slot_registry.sv -----
// Debugger slot registry.
// A request beat is taken at a rising clock edge where start is high and busy
// is low; busy stays high until the request has finished its work. Each result
// beat appears for exactly one cycle with strobe high, and the receiver cannot
// hold it off. A request gives zero or more continue beats (kind 1) followed by
// exactly one final status beat (kind 0, last 1).
// Find, suspend writes, errors and table-full answers are decided in the
// decode state. Attach and detach pass through the target state, and a
// detach that also resumes the target adds a final state. Unregistering a
// debugger walks every process entry through the single read port of the
// per-process memories, one entry per cycle, before the drain and final
// states. Requests are handled one at a time.
// Reset clears the slot table and marks every per-process entry as holding
// no debugger and no suspend bits; the block is ready right after reset.
module debugger_slot_registry #(
    parameter int SLOT_COUNT    = 6,
    parameter int PROCESS_COUNT = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dsr_pkg::ACT_W-1:0]   action,
    input  logic                        debugger_present,
    input  logic                        debugger_found,
    input  logic [dsr_pkg::ID_W-1:0]    debugger_id,
    input  logic                        target_present,
    input  logic                        target_found,
    input  logic [dsr_pkg::ID_W-1:0]    target_id,
    input  logic [dsr_pkg::SUSP_W-1:0]  suspend_bits,
    output logic                        strobe,
    output logic                        kind,
    output logic [dsr_pkg::STAT_W-1:0]  status,
    output logic [dsr_pkg::SLOT_W-1:0]  slot_index,
    output logic [dsr_pkg::ID_W-1:0]    continue_id,
    output logic                        last
);

    // The controller sequences a request; the datapath holds the tables,
    // makes the data-dependent decisions and drives the result registers.
    dsr_pkg::cmd_t cmd;
    dsr_pkg::sts_t sts;

    dsr_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dsr_datapath #(
        .SLOT_COUNT    (SLOT_COUNT),
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .action           (action),
        .debugger_present (debugger_present),
        .debugger_found   (debugger_found),
        .debugger_id      (debugger_id),
        .target_present   (target_present),
        .target_found     (target_found),
        .target_id        (target_id),
        .suspend_bits     (suspend_bits),
        .strobe           (strobe),
        .kind             (kind),
        .status           (status),
        .slot_index       (slot_index),
        .continue_id      (continue_id),
        .last             (last)
    );

endmodule

// ----- sv/dsr_checker.sv -----
module dsr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        strobe,
    input logic                        kind,
    input logic [dsr_pkg::STAT_W-1:0]  status,
    input logic [dsr_pkg::SLOT_W-1:0]  slot_index,
    input logic [dsr_pkg::ID_W-1:0]    continue_id,
    input logic                        last
);

    // A continue beat carries no status or slot and is never the last beat.
    a_continue_fields: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind |-> !last && status == '0 && slot_index == '0)
        else $error("continue beat with final-result fields");

    // A final beat is marked last and names no process.
    a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !kind |-> last && continue_id == '0)
        else $error("final beat malformed");

    // A continue beat is always followed by a final beat, so busy holds.
    a_continue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind |-> busy)
        else $error("continue beat after the request ended");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // Busy only rises from an accepted request.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule

bind debugger_slot_registry dsr_checker u_chk (.*);
